### rtl/core/ffa_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// Depends on nothing; every other file of the block imports it.
package ffa_pkg;

   localparam int REQ_W           = 21;
   localparam int HEAP_W          = 21;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;
   localparam int MAX_CHUNKS_DEF  = 16;
   localparam int ALIGN_BYTES_DEF = 16;
   localparam int OFFSET_BITS_DEF = 20;

   localparam logic [HEAP_W-1:0] HEAP_RESET = 21'h100000;

   // Register index decoded from the word address.
   localparam logic [CSR_ADDR_W-3:0] REG_HEAP_BYTES = 1'b0;

   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_EVAL,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic eval;
      logic commit;
      logic is_free;
   } cell_ctrl_type;

endpackage

### rtl/core/ffa_if.sv
// Valid/ready channel interfaces for the allocator's request and response items.
// Depends on ffa_pkg for the action type and the request width.
interface ffa_req_if #(
   parameter int OFFSET_BITS = ffa_pkg::OFFSET_BITS_DEF
);
   import ffa_pkg::*;

   logic                   valid;
   logic                   ready;
   action_type             action;
   logic [REQ_W-1:0]       request_bytes;
   logic [OFFSET_BITS-1:0] release_offset;

   modport source (output valid, action, request_bytes, release_offset, input ready);
   modport sink   (input valid, action, request_bytes, release_offset, output ready);
endinterface

interface ffa_rsp_if #(
   parameter int OFFSET_BITS = ffa_pkg::OFFSET_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic [OFFSET_BITS-1:0] granted_offset;
   logic                   succeeded;

   modport source (output valid, granted_offset, succeeded, input ready);
   modport sink   (input valid, granted_offset, succeeded, output ready);
endinterface

### rtl/core/first_fit_heap_allocator_top.sv
// An accepted request passes the evaluate state, in which every cell checks its gap, then
// the update state, in which cells shift and its result item is registered. When ALIGN_BYTES is
// not a power of two, a round state comes first, since the size rounding takes a reciprocal multiply.
// The update state can also take the next request; it waits while the last result is still held.
// Reset: synchronous; clears the live count, the state machine and the result valid flag, and
// loads heap_bytes with 1048576. The chunk table itself is not cleared and needs no clearing pass.
module first_fit_heap_allocator_top #(
   parameter int MAX_CHUNKS  = ffa_pkg::MAX_CHUNKS_DEF,
   parameter int ALIGN_BYTES = ffa_pkg::ALIGN_BYTES_DEF,
   parameter int OFFSET_BITS = ffa_pkg::OFFSET_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   ffa_req_if.sink                          req,
   ffa_rsp_if.source                        rsp,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ffa_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [ffa_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [ffa_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import ffa_pkg::*;

   // Widths. A rounded size can exceed the request width by one bit; gap arithmetic needs
   // room for an end of up to 2^OFFSET_BITS plus a size.
   localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);
   localparam int SIZE_W     = REQ_W + 1;
   localparam int WIDE_W     = (OFFSET_BITS + 1 > SIZE_W) ? OFFSET_BITS + 1 : SIZE_W;
   localparam int CALC_W     = WIDE_W + 1;
   localparam int ALIGN_LG   = $clog2(ALIGN_BYTES);
   localparam bit ALIGN_POW2 = ((1 << ALIGN_LG) == ALIGN_BYTES);
   localparam state_type FIRST_STATE = ALIGN_POW2 ? ST_EVAL : ST_ROUND;

   // Control and item registers.
   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [HEAP_W-1:0]      heap_ff, heap_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_BITS-1:0] rsp_offset_ff, rsp_offset_in;
   logic                   rsp_ok_ff, rsp_ok_in;
   action_type             act_ff, act_in;
   logic [OFFSET_BITS-1:0] rel_ff, rel_in;
   logic [SIZE_W-1:0]      size_ff, size_in;
   logic [CALC_W-1:0]      limit_ff, limit_in;

   logic                   accept, finish, slot_free, ok, hit_any, heap_write;
   logic [SIZE_W-1:0]      accept_size, round_size;
   logic [CALC_W-1:0]      heap_ext, heap_cap;
   logic [OFFSET_BITS-1:0] grant_or;
   cell_ctrl_type          ctrl;

   // Neighbor links. Index 0 and MAX_CHUNKS+1 are the empty slots beyond either end of the row.
   logic [OFFSET_BITS-1:0] pad_start [MAX_CHUNKS+2];
   logic [OFFSET_BITS:0]   pad_end   [MAX_CHUNKS+2];
   logic                   hit_chain [MAX_CHUNKS+1];
   logic [OFFSET_BITS-1:0] cell_grant [MAX_CHUNKS];

   // ------------------------------------------------------------------
   // Configuration port. The only register is heap_bytes at word 0; a write to any
   // other word is dropped and reads there return zero.
   // ------------------------------------------------------------------
   assign pready     = 1'b1;
   assign heap_write = psel && penable && pwrite &&
                       (paddr[CSR_ADDR_W-1:2] == REG_HEAP_BYTES);
   assign heap_in    = heap_write ? pwdata[HEAP_W-1:0] : heap_ff;
   assign prdata     = (paddr[CSR_ADDR_W-1:2] == REG_HEAP_BYTES) ?
                       CSR_DATA_W'(heap_ff) : '0;

   // The heap in use is heap_bytes capped at 2^OFFSET_BITS; it is sampled with each item.
   assign heap_ext = CALC_W'(heap_ff);
   assign heap_cap = CALC_W'(1) << OFFSET_BITS;

   // ------------------------------------------------------------------
   // Size rounding. A power-of-two alignment is an add and a mask done on the way in.
   // Any other alignment takes an exact reciprocal multiply for the quotient at accept,
   // then one multiply back by the alignment in the extra rounding cycle.
   // ------------------------------------------------------------------
   if (ALIGN_POW2) begin : g_pow2
      logic [SIZE_W-1:0] bumped;

      assign bumped      = SIZE_W'(req.request_bytes) + SIZE_W'(ALIGN_BYTES - 1);
      assign accept_size = (bumped >> ALIGN_LG) << ALIGN_LG;
      assign round_size  = size_ff;
   end else begin : g_recip
      localparam int PROD_W = 2 * SIZE_W + 1;
      localparam logic [SIZE_W:0] RECIP = (SIZE_W + 1)'(
         ((64'd1 << (SIZE_W + ALIGN_LG)) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));

      logic [SIZE_W-1:0]   bumped, quot_ff, quot_in;
      logic [PROD_W-1:0]   prod;
      logic [2*SIZE_W-1:0] scaled;

      assign bumped  = SIZE_W'(req.request_bytes) + SIZE_W'(ALIGN_BYTES - 1);
      assign prod    = PROD_W'(bumped) * PROD_W'(RECIP);
      assign quot_in = accept ? SIZE_W'(prod >> (SIZE_W + ALIGN_LG)) : quot_ff;

      always_ff @(posedge clock) begin
         quot_ff <= quot_in;
      end

      assign scaled      = (2 * SIZE_W)'(quot_ff) * (2 * SIZE_W)'(ALIGN_BYTES);
      assign round_size  = scaled[SIZE_W-1:0];
      assign accept_size = size_ff;
   end

   // ------------------------------------------------------------------
   // Sequencer: accept, (round), evaluate, update. The update state also takes the next
   // item, so back-to-back traffic overlaps there. The update waits only while
   // the previous result is still held in the output register.
   // ------------------------------------------------------------------
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   always_comb begin : fsm_outputs
      req.ready = 1'b0;
      finish    = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req.ready = 1'b1;
         ST_ROUND:  ;
         ST_EVAL:   ;
         ST_UPDATE: begin
            finish    = slot_free;
            req.ready = slot_free;
         end
      endcase
   end

   always_comb begin : fsm_next
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = FIRST_STATE;
         ST_ROUND:  state_in = ST_EVAL;
         ST_EVAL:   state_in = ST_UPDATE;
         ST_UPDATE: begin
            priority if (accept) state_in = FIRST_STATE;
            else if (finish)     state_in = ST_IDLE;
            else                 state_in = ST_UPDATE;
         end
      endcase
   end

   // Item registers load on accept; the rounded size may load once more in the round cycle.
   assign act_in   = accept ? req.action : act_ff;
   assign rel_in   = accept ? req.release_offset : rel_ff;
   assign limit_in = accept ? ((heap_ext > heap_cap) ? heap_cap : heap_ext) : limit_ff;

   always_comb begin
      priority if (accept)           size_in = accept_size;
      else if (state_ff == ST_ROUND) size_in = round_size;
      else                           size_in = size_ff;
   end

   // ------------------------------------------------------------------
   // Cell row. Each cell checks the gap in front of it during evaluate; during update the
   // first hit along the row writes the new chunk or drops its own, and every cell past it
   // takes its neighbor's chunk so the table stays sorted and packed.
   // ------------------------------------------------------------------
   assign ctrl.eval    = (state_ff == ST_EVAL);
   assign ctrl.is_free = (act_ff == ACT_FREE);
   assign ctrl.commit  = finish && ok;

   assign pad_start[0]            = '0;
   assign pad_end[0]              = '0;
   assign pad_start[MAX_CHUNKS+1] = '0;
   assign pad_end[MAX_CHUNKS+1]   = '0;
   assign hit_chain[0]            = 1'b0;

   for (genvar i = 0; i < MAX_CHUNKS; i++) begin : g_cell
      ffa_cell #(
         .IDX         (i),
         .OFFSET_BITS (OFFSET_BITS),
         .CNT_W       (CNT_W),
         .CALC_W      (CALC_W)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .count       (count_ff),
         .size        (CALC_W'(size_ff)),
         .limit       (limit_ff),
         .rel_offset  (rel_ff),
         .left_start  (pad_start[i]),
         .left_end    (pad_end[i]),
         .right_start (pad_start[i+2]),
         .right_end   (pad_end[i+2]),
         .left_hit    (hit_chain[i]),
         .chunk_start (pad_start[i+1]),
         .chunk_end   (pad_end[i+1]),
         .hit_out     (hit_chain[i+1]),
         .grant       (cell_grant[i])
      );
   end

   // Only the selected cell drives a nonzero grant, so an OR collects it.
   always_comb begin
      grant_or = '0;
      for (int i = 0; i < MAX_CHUNKS; i++) begin
         grant_or = grant_or | cell_grant[i];
      end
   end

   // An allocation also fails on a zero size or a full table; a free needs only a match.
   assign hit_any = hit_chain[MAX_CHUNKS];
   assign ok      = hit_any && ((act_ff == ACT_FREE) ||
                    ((size_ff != '0) && (count_ff < CNT_W'(MAX_CHUNKS))));

   always_comb begin
      count_in = count_ff;
      if (ctrl.commit) begin
         count_in = ctrl.is_free ? count_ff - 1'b1 : count_ff + 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Result register. It holds one item until taken, while the next request is worked on.
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_offset_in = rsp_offset_ff;
      rsp_ok_in     = rsp_ok_ff;
      if (finish) begin
         rsp_valid_in  = 1'b1;
         rsp_offset_in = (ok && (act_ff == ACT_ALLOC)) ? grant_or : '0;
         rsp_ok_in     = ok;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.granted_offset = rsp_offset_ff;
   assign rsp.succeeded      = rsp_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         heap_ff      <= HEAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         heap_ff      <= heap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      rel_ff        <= rel_in;
      size_ff       <= size_in;
      limit_ff      <= limit_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_ok_ff     <= rsp_ok_in;
   end

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_CHUNKS))
      else $error("live chunk count exceeds the table depth");

   a_free_shrinks: assert property (@(posedge clock) disable iff (reset)
      (ctrl.commit && ctrl.is_free) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("a successful free did not shrink the table by one");

   a_grant_fits: assert property (@(posedge clock) disable iff (reset)
      (ctrl.commit && !ctrl.is_free) |->
         ((CALC_W'(grant_or) + CALC_W'(size_ff)) <= limit_ff))
      else $error("granted chunk runs past the heap end");

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("result item raised outside the update cycle");

endmodule

### rtl/core/ffa_cell.sv
// One slot of the sorted chunk table: holds a chunk's start and end and talks to its neighbors.
// Depends on ffa_pkg for the control struct.
module ffa_cell #(
   parameter int IDX         = 0,
   parameter int OFFSET_BITS = ffa_pkg::OFFSET_BITS_DEF,
   parameter int CNT_W       = 5,
   parameter int CALC_W      = 23
) (
   input  logic                    clock,
   input  ffa_pkg::cell_ctrl_type  ctrl,
   input  logic [CNT_W-1:0]        count,
   input  logic [CALC_W-1:0]       size,
   input  logic [CALC_W-1:0]       limit,
   input  logic [OFFSET_BITS-1:0]  rel_offset,
   input  logic [OFFSET_BITS-1:0]  left_start,
   input  logic [OFFSET_BITS:0]    left_end,
   input  logic [OFFSET_BITS-1:0]  right_start,
   input  logic [OFFSET_BITS:0]    right_end,
   input  logic                    left_hit,
   output logic [OFFSET_BITS-1:0]  chunk_start,
   output logic [OFFSET_BITS:0]    chunk_end,
   output logic                    hit_out,
   output logic [OFFSET_BITS-1:0]  grant
);
   import ffa_pkg::*;

   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [OFFSET_BITS:0]   end_ff, end_in;
   logic                   fit_ff, fit_in;
   logic                   valid, at_tail, alloc_fit, free_fit, sel;
   logic [CALC_W-1:0]      cursor, new_end;

   // The gap in front of this slot begins where the left neighbor ends.
   assign valid   = CNT_W'(IDX) < count;
   assign at_tail = CNT_W'(IDX) == count;
   assign cursor  = CALC_W'(left_end);
   assign new_end = cursor + size;

   assign alloc_fit = (valid || at_tail) && (new_end <= limit) &&
                      (!valid || (new_end <= CALC_W'(start_ff)));
   assign free_fit  = valid && (start_ff == rel_offset);

   assign fit_in  = ctrl.eval ? (ctrl.is_free ? free_fit : alloc_fit) : fit_ff;
   assign hit_out = left_hit | fit_ff;
   assign sel     = fit_ff & ~left_hit;
   assign grant   = sel ? cursor[OFFSET_BITS-1:0] : '0;

   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      if (ctrl.commit) begin
         if (ctrl.is_free) begin
            // Slots from the removed one upward close the hole.
            if (hit_out) begin
               start_in = right_start;
               end_in   = right_end;
            end
         end else begin
            // Slots above the insert point move up by one.
            priority if (left_hit) begin
               start_in = left_start;
               end_in   = left_end;
            end else if (fit_ff) begin
               start_in = cursor[OFFSET_BITS-1:0];
               end_in   = new_end[OFFSET_BITS:0];
            end else begin
               start_in = start_ff;
               end_in   = end_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      end_ff   <= end_in;
      fit_ff   <= fit_in;
   end

   assign chunk_start = start_ff;
   assign chunk_end   = end_ff;

endmodule
